// ===== src/bdm_pkg.sv =====
// Shared types and constants for the Bayer demosaic block.
// No dependencies; imported by bdm_kernel and bayer_demosaic_mhc.
`timescale 1ns / 1ps

package bdm_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam int unsigned CFG_DATA_W  = 13;

  // Frame geometry limits and reset values
  localparam int unsigned WIDTH_W      = 12;
  localparam int unsigned HEIGHT_W     = 13;
  localparam int unsigned MIN_DIM      = 4;
  localparam int unsigned MAX_HEIGHT   = 4096;
  localparam int unsigned RESET_WIDTH  = 256;
  localparam int unsigned RESET_HEIGHT = 256;

  // Line store rows (5x5 window needs four stored rows plus the live one)
  localparam int unsigned LINE_BUFFERS = 4;
  localparam int unsigned LB_SEL_W     = 2;

  // Input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] raw_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } out_beat_t;

  // Position of the output pixel, reduced to what the kernels need
  typedef struct packed {
    logic r_first;      // row 0
    logic r_second;     // row 1
    logic r_last;       // row H-1
    logic r_next_last;  // row H-2
    logic c_first;
    logic c_second;
    logic c_last;
    logic c_next_last;
    logic r_odd;
    logic c_odd;
    logic frame_end;
  } pos_flags_t;

  typedef logic [4:0][4:0][7:0] window_t;  // [column][row]

endpackage

// ===== src/bdm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bdm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a same-address write returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bdm_kernel.sv =====
// Border mirroring and Malvar-He-Cutler 5x5 kernels for one output pixel.
// Depends on bdm_pkg (window_t, pos_flags_t, out_beat_t).
`timescale 1ns / 1ps

module bdm_kernel import bdm_pkg::*; (
  input  window_t    win,
  input  pos_flags_t flags,
  output out_beat_t  pix
);

  window_t  mw;
  logic [2:0] rsel [5];
  logic [2:0] csel [5];
  logic signed [15:0] p, l, r, u, d, ll, rr, uu, dd, diag;
  logic signed [15:0] s_grb, s_h, s_v, s_opp;
  logic [7:0] g_rb, c_h, c_v, c_opp;

  function automatic logic signed [15:0] ext(input logic [7:0] v);
    return signed'({8'd0, v});
  endfunction

  // Negative gives zero, else floor by 2^sh and saturate
  function automatic logic [7:0] finish(input logic signed [15:0] s, input logic sh4);
    logic signed [15:0] t;
    t = sh4 ? (s >>> 4) : (s >>> 3);
    if (s < 0) return 8'd0;
    if (t > 16'sd255) return 8'd255;
    return t[7:0];
  endfunction

  // Mirror selects: edge sample is not repeated
  always_comb begin
    rsel[0] = flags.r_first ? 3'd4 : (flags.r_second ? 3'd2 : 3'd0);
    rsel[1] = flags.r_first ? 3'd3 : 3'd1;
    rsel[2] = 3'd2;
    rsel[3] = flags.r_last ? 3'd1 : 3'd3;
    rsel[4] = flags.r_last ? 3'd0 : (flags.r_next_last ? 3'd2 : 3'd4);
    csel[0] = flags.c_first ? 3'd4 : (flags.c_second ? 3'd2 : 3'd0);
    csel[1] = flags.c_first ? 3'd3 : 3'd1;
    csel[2] = 3'd2;
    csel[3] = flags.c_last ? 3'd1 : 3'd3;
    csel[4] = flags.c_last ? 3'd0 : (flags.c_next_last ? 3'd2 : 3'd4);
    for (int k = 0; k < 5; k++) begin
      for (int j = 0; j < 5; j++) begin
        mw[k][j] = win[csel[k]][rsel[j]];
      end
    end
  end

  // Taps around the center, mw[column][row]
  always_comb begin
    p    = ext(mw[2][2]);
    l    = ext(mw[1][2]);
    r    = ext(mw[3][2]);
    u    = ext(mw[2][1]);
    d    = ext(mw[2][3]);
    ll   = ext(mw[0][2]);
    rr   = ext(mw[4][2]);
    uu   = ext(mw[2][0]);
    dd   = ext(mw[2][4]);
    diag = ext(mw[1][1]) + ext(mw[3][1]) + ext(mw[1][3]) + ext(mw[3][3]);
  end

  // Kernel sums
  always_comb begin
    s_grb = 16'sd4 * p + 16'sd2 * (l + r + u + d) - (ll + rr + uu + dd);
    s_h   = 16'sd10 * p + 16'sd8 * (l + r) - 16'sd2 * (ll + rr + diag) + (uu + dd);
    s_v   = 16'sd10 * p + 16'sd8 * (u + d) - 16'sd2 * (uu + dd + diag) + (ll + rr);
    s_opp = 16'sd12 * p + 16'sd4 * diag - 16'sd3 * (ll + rr + uu + dd);
    g_rb  = finish(s_grb, 1'b0);
    c_h   = finish(s_h, 1'b1);
    c_v   = finish(s_v, 1'b1);
    c_opp = finish(s_opp, 1'b1);
  end

  // Pick by Bayer site
  always_comb begin
    pix.frame_end = flags.frame_end;
    if (flags.r_odd == flags.c_odd) begin
      pix.green = mw[2][2];
      pix.red   = flags.r_odd ? c_v : c_h;
      pix.blue  = flags.r_odd ? c_h : c_v;
    end else if (!flags.r_odd) begin
      pix.red   = mw[2][2];
      pix.green = g_rb;
      pix.blue  = c_opp;
    end else begin
      pix.blue  = mw[2][2];
      pix.green = g_rb;
      pix.red   = c_opp;
    end
  end

endmodule

// ===== src/bayer_demosaic_mhc.sv =====
// Bayer-to-RGB demosaic, top level: counters, line store, window and output register.
// Depends on bdm_pkg, bdm_ram and bdm_kernel.
`timescale 1ns / 1ps

// One beat in, at most one pixel out, one beat per clock sustained while out_ready
// keeps the output moving. A beat goes through three registers (line store read,
// 5x5 window, output register) before the pixel it completes leaves. Output
// (r,c) appears on the beat for raster position (r+2,c+2); after the last raw
// pixel of a frame send 2*width+2 drain beats (cmd=1). Drain beats during a
// frame are dropped; raw pixels after the frame's last row count as drain.
// Phase: G at even/even and odd/odd, R at even row/odd column, B at odd/even.
// Borders are mirrored. A width or height register write restarts the frame.

module bayer_demosaic_mhc import bdm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [WIDTH_W-1:0]  col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;

  logic en, in_fire, drop, real_px, emit;
  logic [HEIGHT_W-1:0] out_row;
  logic [WIDTH_W-1:0]  out_col;
  pos_flags_t flags0;

  // Stage 1: line store read in flight
  logic                v1_r, real1_r, emit1_r;
  logic [7:0]          pix1_r;
  logic [LB_SEL_W-1:0] rb1_r;
  pos_flags_t          flags1_r;
  logic [7:0]          ram_q [LINE_BUFFERS];

  // Stage 2: window
  window_t    win_r, win_nxt;
  logic       v2_r;
  pos_flags_t flags2_r;

  // Stage 3: output
  logic      out_valid_r;
  out_beat_t out_data_r, kern_pix;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && en;

  // Raster position bookkeeping
  always_comb begin
    real_px = (in_data.cmd == CMD_PIXEL) && (row_r < height_r);
    drop    = (in_data.cmd == CMD_DRAIN) && (row_r < height_r);
    if (col_r >= WIDTH_W'(2)) begin
      emit    = row_r >= HEIGHT_W'(2);
      out_row = row_r - HEIGHT_W'(2);
      out_col = col_r - WIDTH_W'(2);
    end else begin
      emit    = row_r >= HEIGHT_W'(3);
      out_row = row_r - HEIGHT_W'(3);
      out_col = width_r - WIDTH_W'(2) + col_r;
    end
    flags0.r_first     = out_row == '0;
    flags0.r_second    = out_row == HEIGHT_W'(1);
    flags0.r_last      = out_row == height_r - HEIGHT_W'(1);
    flags0.r_next_last = out_row == height_r - HEIGHT_W'(2);
    flags0.c_first     = out_col == '0;
    flags0.c_second    = out_col == WIDTH_W'(1);
    flags0.c_last      = out_col == width_r - WIDTH_W'(1);
    flags0.c_next_last = out_col == width_r - WIDTH_W'(2);
    flags0.r_odd       = out_row[0];
    flags0.c_odd       = out_col[0];
    flags0.frame_end   = flags0.r_last && flags0.c_last;
  end

  // Counters and configuration
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT)) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        if (cfg_wdata[WIDTH_W-1:0] < WIDTH_W'(MIN_DIM)) begin
          width_nxt = WIDTH_W'(MIN_DIM);
        end else if ({2'b00, cfg_wdata[WIDTH_W-1:0]} > 14'(MAX_WIDTH)) begin
          width_nxt = WIDTH_W'(MAX_WIDTH);
        end else begin
          width_nxt = cfg_wdata[WIDTH_W-1:0];
        end
      end else begin
        if (cfg_wdata < HEIGHT_W'(MIN_DIM)) begin
          height_nxt = HEIGHT_W'(MIN_DIM);
        end else if (cfg_wdata > HEIGHT_W'(MAX_HEIGHT)) begin
          height_nxt = HEIGHT_W'(MAX_HEIGHT);
        end else begin
          height_nxt = cfg_wdata;
        end
      end
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire && !drop) begin
      if (emit && flags0.frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r + WIDTH_W'(1) >= width_r) begin
        col_nxt = '0;
        row_nxt = row_r + HEIGHT_W'(1);
      end else begin
        col_nxt = col_r + WIDTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(RESET_WIDTH);
      height_r <= HEIGHT_W'(RESET_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // Line store: one RAM per stored row
  for (genvar g = 0; g < LINE_BUFFERS; g++) begin : g_line
    bdm_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (in_fire && real_px && (row_r[LB_SEL_W-1:0] == LB_SEL_W'(g))),
      .waddr (AW'(col_r)),
      .wdata (in_data.raw_pixel),
      .re    (in_fire && !drop),
      .raddr (AW'(col_r)),
      .rdata (ram_q[g])
    );
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_fire && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !drop) begin
      real1_r  <= real_px;
      emit1_r  <= emit;
      pix1_r   <= in_data.raw_pixel;
      rb1_r    <= row_r[LB_SEL_W-1:0];
      flags1_r <= flags0;
    end
  end

  // Window shift: new column holds rows R-4..R
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      win_nxt[k] = win_r[k+1];
    end
    for (int j = 0; j < 4; j++) begin
      win_nxt[4][j] = ram_q[LB_SEL_W'(rb1_r + LB_SEL_W'(j))];
    end
    win_nxt[4][4] = real1_r ? pix1_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      v2_r  <= 1'b0;
    end else if (en) begin
      if (v1_r) begin
        win_r <= win_nxt;
      end
      v2_r <= v1_r && emit1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v1_r) begin
      flags2_r <= flags1_r;
    end
  end

  bdm_kernel u_kernel (
    .win   (win_r),
    .flags (flags2_r),
    .pix   (kern_pix)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2_r) begin
      out_data_r <= kern_pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/tb_bayer_demosaic_mhc.sv =====
// Testbench for bayer_demosaic_mhc: raw Bayer frames in, RGB pixels checked
// against a behavioral 5x5 Malvar-He-Cutler predictor. Depends on bdm_pkg.
`timescale 1ns / 1ps

module tb_bayer_demosaic_mhc;
  import bdm_pkg::*;

  localparam int STORE_W    = 2048;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYC = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bayer_demosaic_mhc u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [7:0] row_store [LINE_BUFFERS*STORE_W];
  logic [7:0] win [25];
  int unsigned col_in, row_in, frm_w, frm_h;

  out_beat_t expected_pixels [$];
  int        err_count;
  int        beats_sent;
  bit        no_idle;
  int        idle_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic int fold(input int v, input int n);
    if (v < 0) v = -v;
    if (v > n - 1) v = 2 * (n - 1) - v;
    return v;
  endfunction

  function automatic int tap(input int r, input int c, input int dr, input int dc);
    int y, x;
    y = fold(r + dr, frm_h);
    x = fold(c + dc, frm_w);
    return int'(win[((x + 2 - c) % 5) * 5 + ((y + 2 - r) % 5)]);
  endfunction

  function automatic logic [7:0] clip(input int s, input int sh);
    if (s < 0) return 8'd0;
    s = s >>> sh;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic int corners(input int r, input int c);
    return tap(r, c, -1, -1) + tap(r, c, -1, 1) + tap(r, c, 1, -1) + tap(r, c, 1, 1);
  endfunction

  function automatic logic [7:0] green_rb(input int r, input int c);
    int s;
    s = 4 * tap(r, c, 0, 0)
      + 2 * (tap(r, c, 0, -1) + tap(r, c, 0, 1) + tap(r, c, -1, 0) + tap(r, c, 1, 0))
      - (tap(r, c, 0, -2) + tap(r, c, 0, 2) + tap(r, c, -2, 0) + tap(r, c, 2, 0));
    return clip(s, 3);
  endfunction

  // color beside a green site: horizontal neighbors (vert=0) or vertical (vert=1)
  function automatic logic [7:0] beside_green(input int r, input int c, input bit vert);
    int a, b, s;
    a = vert ? 1 : 0;
    b = vert ? 0 : 1;
    s = 10 * tap(r, c, 0, 0)
      + 8 * (tap(r, c, -a, -b) + tap(r, c, a, b))
      - 2 * (tap(r, c, -2*a, -2*b) + tap(r, c, 2*a, 2*b) + corners(r, c))
      + (tap(r, c, -2*b, -2*a) + tap(r, c, 2*b, 2*a));
    return clip(s, 4);
  endfunction

  function automatic logic [7:0] across_site(input int r, input int c);
    int s;
    s = 12 * tap(r, c, 0, 0) + 4 * corners(r, c)
      - 3 * (tap(r, c, 0, -2) + tap(r, c, 0, 2) + tap(r, c, -2, 0) + tap(r, c, 2, 0));
    return clip(s, 4);
  endfunction

  // advance the predictor by one accepted beat; queue a pixel if one is due
  function automatic void demosaic_step(input in_beat_t b);
    int R, C, r, c;
    bit live;
    out_beat_t o;
    R = row_in;
    C = col_in;
    live = (b.cmd == CMD_PIXEL) && (R < frm_h);
    if (!live && R < frm_h) return;
    if (C >= frm_w) C = 0;
    for (int k = 0; k < 20; k++) win[k] = win[k + 5];
    for (int j = 0; j < 4; j++) win[20 + j] = row_store[((R + j) % LINE_BUFFERS) * STORE_W + C];
    win[24] = live ? b.raw_pixel : 8'd0;
    if (live) row_store[(R % LINE_BUFFERS) * STORE_W + C] = b.raw_pixel;
    if (C >= 2) begin
      r = R - 2;
      c = C - 2;
    end else begin
      r = R - 3;
      c = frm_w - 2 + C;
    end
    col_in = C + 1;
    if (col_in >= frm_w) begin
      col_in = 0;
      row_in = R + 1;
    end
    if (r < 0) return;
    if (r[0] == c[0]) begin
      o.green = win[12];
      o.red   = beside_green(r, c, r[0]);
      o.blue  = beside_green(r, c, !r[0]);
    end else if (!r[0]) begin
      o.red   = win[12];
      o.green = green_rb(r, c);
      o.blue  = across_site(r, c);
    end else begin
      o.blue  = win[12];
      o.green = green_rb(r, c);
      o.red   = across_site(r, c);
    end
    o.frame_end = (r == frm_h - 1) && (c == frm_w - 1);
    if (o.frame_end) begin
      col_in = 0;
      row_in = 0;
    end
    expected_pixels.push_back(o);
  endfunction

  // ---------------- shared tasks ----------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // send one beat; called and returns at a rising edge
  task automatic send_beat(input logic cmd, input logic [7:0] pix);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, raw_pixel: pix};
    forever begin
      @(negedge clk);
      if (in_ready) begin
        demosaic_step(in_data);
        beats_sent++;
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  // wait until every expected pixel has come and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int v;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      v = val & 13'hFFF;
      frm_w = (v < MIN_DIM) ? MIN_DIM : (v > STORE_W) ? STORE_W : v;
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      v = val;
      frm_h = (v < MIN_DIM) ? MIN_DIM : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
    end
    if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT) begin
      col_in = 0;
      row_in = 0;
    end
    @(posedge clk);
  endtask

  // pixel content: 0 random, 1 all dark, 2 all bright, 3 random dark/bright
  function automatic logic [7:0] pick_pixel(input int mode);
    case (mode)
      1: return 8'd0;
      2: return 8'd255;
      3: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one frame of the current geometry: pixels, then the drain tail
  task automatic run_frame(input int mode, input bit noise, input bit pause);
    int n, pause_at;
    n = frm_w * frm_h;
    pause_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      // stray drain beats mid-frame are ignored
      if (noise && $urandom_range(0, 15) == 0) send_beat(CMD_DRAIN, 8'($urandom_range(0, 255)));
      if (pause && i == pause_at) settle();
      send_beat(CMD_PIXEL, pick_pixel(mode));
    end
    // drain tail; some beats carry a pixel that must count as drain
    for (int i = 0; i < 2 * frm_w + 2; i++)
      send_beat((noise && $urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_DRAIN,
                8'($urandom_range(0, 255)));
    settle();
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  // ---------------- tests ----------------
  task automatic test_flat_and_clamp();
    // below-minimum values clamp to the smallest frame
    set_size(0, 0);
    run_frame(1, 0, 0);
    run_frame(2, 0, 0);
    run_frame(3, 1, 0);
    set_size(5, 4);
    run_frame(0, 1, 0);
  endtask

  task automatic test_unused_index();
    write_reg(2'd2, 13'h1FFF);
    write_reg(2'd3, 13'h0AAA);
    run_frame(0, 0, 0);
  endtask

  task automatic test_abort();
    set_size(7, 6);
    for (int i = 0; i < 20; i++) send_beat(CMD_PIXEL, 8'($urandom_range(0, 255)));
    settle();
    set_size(6, 5);
    run_frame(0, 0, 0);
  endtask

  task automatic test_random_frames();
    int start;
    start = beats_sent;
    while (beats_sent - start < 650) begin
      no_idle = ($urandom_range(0, 4) == 0);
      write_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 5) == 0)
                                 ? CFG_DATA_W'($urandom_range(4, 40))
                                 : CFG_DATA_W'($urandom_range(4, 12)));
      write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(4, 8)));
      run_frame($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0,
                1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_largest();
    // width keeps only its low 12 bits before clamping
    no_idle = 1'b1;
    write_reg(CFG_IMAGE_WIDTH, 13'h1005);
    write_reg(CFG_IMAGE_HEIGHT, 13'd4);
    run_frame(0, 0, 0);
    // widest row: a short start of the frame, then aborted
    write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(CFG_IMAGE_HEIGHT, 13'd4);
    for (int i = 0; i < 16; i++) send_beat(CMD_PIXEL, 8'($urandom_range(0, 255)));
    settle();
    // tallest frame: top rows only, then aborted
    write_reg(CFG_IMAGE_WIDTH, 13'd4);
    write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 24; i++) send_beat(CMD_PIXEL, 8'($urandom_range(0, 255)));
    settle();
    no_idle = 1'b0;
  endtask

  // ---------------- result side ----------------
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 13);
      out_ready <= (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
      do @(negedge clk); while (!out_valid);
    end
  end

  // compare each accepted beat with the oldest expectation
  always @(negedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, red", out_data.red, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.red !== want.red) report_mismatch("red", out_data.red, want.red);
        if (out_data.green !== want.green) report_mismatch("green", out_data.green, want.green);
        if (out_data.blue !== want.blue) report_mismatch("blue", out_data.blue, want.blue);
        if (out_data.frame_end !== want.frame_end)
          report_mismatch("frame_end", out_data.frame_end, want.frame_end);
      end
    end
  end

  // watchdog: no beat on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    err_count = 0;
    beats_sent = 0;
    no_idle = 1'b0;
    idle_cycles = 0;
    frm_w = RESET_WIDTH;
    frm_h = RESET_HEIGHT;
    col_in = 0;
    row_in = 0;
    for (int k = 0; k < 25; k++) win[k] = 8'd0;
    for (int k = 0; k < LINE_BUFFERS * STORE_W; k++) row_store[k] = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_flat_and_clamp();
    test_unused_index();
    test_abort();
    test_random_frames();
    test_largest();
    settle();

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
